### hdl/vic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vectored interrupt controller package
// Register offsets, action codes, sizing constants and the identification
// byte table shared by the controller modules.
// ----------------------------------------------------------------------------
package vic_pkg;

    // Default number of prioritised vector slots.
    localparam int NUM_VECTORS_DEF = 16;

    // Number of interrupt sources and width of a source number.
    localparam int NUM_SOURCES = 32;
    localparam int SRC_W       = 5;

    // Width of a vector control word: enable bit over a source number.
    localparam int CTRL_W      = 6;
    localparam int CTRL_EN_BIT = 5;

    // Peripheral identification word, returned a byte at a time.
    localparam logic [31:0] PERIPH_ID = 32'h0004_1190;

    // Kind of work carried by one input beat.
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_RAISE = 2'd2,
        ACT_LOWER = 2'd3
    } action_t;

    // Register offsets in the low part of the window.
    localparam logic [11:0] REG_IRQ_STATUS = 12'h000;
    localparam logic [11:0] REG_FIQ_STATUS = 12'h004;
    localparam logic [11:0] REG_RAW_STATUS = 12'h008;
    localparam logic [11:0] REG_INT_SELECT = 12'h00c;
    localparam logic [11:0] REG_ENABLE     = 12'h010;
    localparam logic [11:0] REG_ENABLE_CLR = 12'h014;
    localparam logic [11:0] REG_SOFT       = 12'h018;
    localparam logic [11:0] REG_SOFT_CLR   = 12'h01c;
    localparam logic [11:0] REG_PROTECTION = 12'h020;
    localparam logic [11:0] REG_RESERVED   = 12'h024;
    localparam logic [11:0] REG_VECT_ADDR  = 12'h030;
    localparam logic [11:0] REG_DEF_ADDR   = 12'h034;

    // Window boundaries.
    localparam logic [11:0] WIN_ID_BASE   = 12'hfe0;
    localparam logic [11:0] WIN_CTRL_BASE = 12'h200;

    // Identification byte for one word of the identification window.
    function automatic logic [7:0] id_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = PERIPH_ID[7:0];
            3'd1:    b = PERIPH_ID[15:8];
            3'd2:    b = PERIPH_ID[23:16];
            3'd3:    b = PERIPH_ID[31:24];
            3'd4:    b = 8'h0d;
            3'd5:    b = 8'hf0;
            3'd6:    b = 8'h05;
            3'd7:    b = 8'hb1;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### hdl/vic_prio.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority encoder
// Finds the highest priority pending vector slot and forms the source mask
// that the current priority level lets through to the interrupt outputs.
// ----------------------------------------------------------------------------
module vic_prio
    import vic_pkg::*;
#(
    parameter int NUM_VECTORS = NUM_VECTORS_DEF,
    localparam int LW = $clog2(NUM_VECTORS + 2)
)
(
    input  logic [NUM_VECTORS-1:0][CTRL_W-1:0] ctrl,
    input  logic [LW-1:0]                      cur_level,
    input  logic [NUM_SOURCES-1:0]             pending,
    output logic                               take_hit,
    output logic [LW-1:0]                      take_level,
    output logic [NUM_SOURCES-1:0]             level_mask
);

    localparam logic [LW-1:0] LEVEL_NONE = LW'(NUM_VECTORS + 1);

    logic [NUM_VECTORS-1:0] contrib;
    logic                   found;
    logic [LW-1:0]          first_level;

    // A slot contributes when it is enabled and its source is pending.
    always_comb
    begin
        for (int s = 0; s < NUM_VECTORS; s++)
        begin
            contrib[s] = ctrl[s][CTRL_EN_BIT] && pending[ctrl[s][SRC_W-1:0]];
        end
    end

    // The lowest contributing slot wins; any other pending source falls to
    // the default level, which sits just below all slots.
    always_comb
    begin
        first_level = LW'(NUM_VECTORS);
        for (int s = NUM_VECTORS - 1; s >= 0; s--)
        begin
            if (contrib[s])
            begin
                first_level = LW'(s);
            end
        end
        found      = (|contrib) || (|pending);
        take_level = first_level;
        take_hit   = found && (first_level < cur_level);
    end

    // Sources owned by slots above the current level, or all of them when
    // no level is active.
    always_comb
    begin
        level_mask = '0;
        for (int s = 0; s < NUM_VECTORS; s++)
        begin
            if ((LW'(s) < cur_level) && ctrl[s][CTRL_EN_BIT])
            begin
                level_mask = level_mask
                           | (NUM_SOURCES'(1) << ctrl[s][SRC_W-1:0]);
            end
        end
        if (cur_level == LEVEL_NONE)
        begin
            level_mask = '1;
        end
    end

endmodule

### hdl/vic_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Controller register file and item decoder
// Holds all controller state, decodes one beat per step and produces its
// read data and error flag; drives the irq and fiq levels from the state.
// ----------------------------------------------------------------------------
module vic_core
    import vic_pkg::*;
#(
    parameter int NUM_VECTORS = NUM_VECTORS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [1:0]  action,
    input  logic [11:0] offset,
    input  logic [31:0] write_data,
    input  logic [4:0]  line_index,
    output logic [31:0] rdata,
    output logic        err,
    output logic        irq,
    output logic        fiq
);

    localparam int LW  = $clog2(NUM_VECTORS + 2);
    localparam int SW  = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
    localparam int SVW = $clog2(NUM_VECTORS + 1);
    localparam logic [LW-1:0] LEVEL_NONE = LW'(NUM_VECTORS + 1);

    // State registers.
    logic [31:0] raw_reg,     raw_next;
    logic [31:0] soft_reg,    soft_next;
    logic [31:0] enable_reg,  enable_next;
    logic [31:0] fast_reg,    fast_next;
    logic [31:0] defaddr_reg, defaddr_next;
    logic [LW-1:0] level_reg, level_next;
    logic [31:0] vaddr_reg [NUM_VECTORS];
    logic [NUM_VECTORS-1:0][CTRL_W-1:0] ctrl_reg;
    logic [LW-1:0] saved_reg [NUM_VECTORS + 1];

    // Decode and priority signals.
    action_t       act;
    logic [31:0]   pending;
    logic          take_hit;
    logic [LW-1:0] take_level;
    logic [31:0]   level_mask;
    logic          id_win;
    logic          ctrl_win;
    logic          addr_win;
    logic          ctrl_slot_ok;
    logic          addr_slot_ok;
    logic [SW-1:0] win_slot;
    logic [LW-1:0] vect_level;
    logic [SW-1:0] rd_slot;
    logic [31:0]   vaddr_rd;
    logic          push;
    logic          vaddr_we;
    logic          ctrl_we;

    assign act     = action_t'(action);
    assign pending = raw_reg | soft_reg;

    vic_prio #(
        .NUM_VECTORS (NUM_VECTORS)
    ) u_prio (
        .ctrl       (ctrl_reg),
        .cur_level  (level_reg),
        .pending    (pending),
        .take_hit   (take_hit),
        .take_level (take_level),
        .level_mask (level_mask)
    );

    // Interrupt levels follow the state left by the last beat.
    assign irq = |(pending & enable_reg & ~fast_reg & level_mask);
    assign fiq = |(pending & enable_reg & fast_reg & level_mask);

    // Window decode.
    assign id_win       = offset >= WIN_ID_BASE;
    assign ctrl_win     = !id_win && (offset >= WIN_CTRL_BASE);
    assign addr_win     = offset[11:8] == 4'h1;
    assign ctrl_slot_ok = (offset[11:9] == 3'b001) && (offset[8:2] < 7'(NUM_VECTORS));
    assign addr_slot_ok = addr_win && (offset[7:2] < 6'(NUM_VECTORS));
    assign win_slot     = offset[2 +: SW];

    // Vector address read port: the bus slot, or the level a vector read
    // lands on.
    assign vect_level = take_hit ? take_level : level_reg;
    assign rd_slot    = (offset == REG_VECT_ADDR) ? vect_level[SW-1:0] : win_slot;
    assign vaddr_rd   = vaddr_reg[rd_slot];

    // Read data, error and next state for one beat.
    always_comb
    begin
        rdata        = '0;
        err          = 1'b0;
        raw_next     = raw_reg;
        soft_next    = soft_reg;
        enable_next  = enable_reg;
        fast_next    = fast_reg;
        defaddr_next = defaddr_reg;
        level_next   = level_reg;
        push         = 1'b0;
        vaddr_we     = 1'b0;
        ctrl_we      = 1'b0;
        case (act)
            ACT_READ:
            begin
                if (id_win)
                begin
                    rdata = {24'h0, id_byte(offset[4:2])};
                end
                else if (ctrl_win)
                begin
                    if (ctrl_slot_ok)
                    begin
                        rdata = {26'h0, ctrl_reg[win_slot]};
                    end
                end
                else if (addr_win)
                begin
                    if (addr_slot_ok)
                    begin
                        rdata = vaddr_rd;
                    end
                end
                else
                begin
                    case (offset)
                        REG_IRQ_STATUS: rdata = pending & enable_reg & ~fast_reg;
                        REG_FIQ_STATUS: rdata = pending & enable_reg & fast_reg;
                        REG_RAW_STATUS: rdata = pending;
                        REG_INT_SELECT: rdata = fast_reg;
                        REG_ENABLE:     rdata = enable_reg;
                        REG_SOFT:       rdata = soft_reg;
                        REG_RESERVED:   rdata = '0;
                        REG_VECT_ADDR:
                        begin
                            // Nest the winning level and return its address.
                            push       = take_hit;
                            level_next = vect_level;
                            rdata      = (vect_level < LW'(NUM_VECTORS)) ? vaddr_rd
                                                                         : defaddr_reg;
                        end
                        REG_DEF_ADDR:   rdata = defaddr_reg;
                        default:        err   = 1'b1;
                    endcase
                end
            end
            ACT_WRITE:
            begin
                if (id_win)
                begin
                    err = 1'b0;
                end
                else if (ctrl_win)
                begin
                    ctrl_we = ctrl_slot_ok;
                end
                else if (addr_win)
                begin
                    vaddr_we = addr_slot_ok;
                end
                else
                begin
                    case (offset)
                        REG_IRQ_STATUS,
                        REG_FIQ_STATUS,
                        REG_RAW_STATUS: err = 1'b0;
                        REG_INT_SELECT: fast_next   = write_data;
                        REG_ENABLE:     enable_next = enable_reg | write_data;
                        REG_ENABLE_CLR: enable_next = enable_reg & ~write_data;
                        REG_SOFT:       soft_next   = soft_reg | write_data;
                        REG_SOFT_CLR:   soft_next   = soft_reg & ~write_data;
                        REG_VECT_ADDR:
                        begin
                            // Pop one nesting level.
                            if (level_reg != LEVEL_NONE)
                            begin
                                level_next = saved_reg[level_reg[SVW-1:0]];
                            end
                        end
                        REG_DEF_ADDR:   defaddr_next = write_data;
                        REG_PROTECTION: err = 1'b1;
                        default:        err = 1'b1;
                    endcase
                end
            end
            ACT_RAISE: raw_next = raw_reg | (32'(1) << line_index);
            ACT_LOWER: raw_next = raw_reg & ~(32'(1) << line_index);
            default:   err = 1'b0;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg     <= '0;
            soft_reg    <= '0;
            enable_reg  <= '0;
            fast_reg    <= '0;
            defaddr_reg <= '0;
            level_reg   <= LEVEL_NONE;
            ctrl_reg    <= '0;
        end
        else if (step)
        begin
            raw_reg     <= raw_next;
            soft_reg    <= soft_next;
            enable_reg  <= enable_next;
            fast_reg    <= fast_next;
            defaddr_reg <= defaddr_next;
            level_reg   <= level_next;
            if (ctrl_we)
            begin
                ctrl_reg[win_slot] <= write_data[CTRL_W-1:0];
            end
        end
    end

    // Vector address table, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_VECTORS; s++)
            begin
                vaddr_reg[s] <= '0;
            end
        end
        else if (step && vaddr_we)
        begin
            vaddr_reg[win_slot] <= write_data;
        end
    end

    // Nesting stack: the entry for the new level remembers the old one.
    always_ff @(posedge clk)
    begin
        if (step && push)
        begin
            saved_reg[take_level[SVW-1:0]] <= level_reg;
        end
    end

endmodule

### hdl/vectored_interrupt_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vectored interrupt controller
// 32 interrupt sources with prioritised vector slots, a default vector and
// a priority nesting stack behind a register window.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat (in_valid/in_ready) is a bus read, a bus write, or an
// interrupt source line rising or falling, chosen by action. Each input beat
// gives exactly one output beat (out_valid/out_ready) carrying the read data
// and the error flag, in order.
// An accepted beat is held in an input register, decoded and applied to the
// controller state once the output register is free or emptying, and its
// result is presented from the output register; throughput is one beat per
// cycle while the receiver does not stall. The decode and the priority
// encoder over the vector slots are combinational.
// irq_out and fiq_out show the interrupt levels as left by the beat on the
// output port and stay valid while that beat waits.
// When the receiver stalls, the waiting result holds and one further input
// beat is taken into the input register; after that in_ready falls.
// Reset clears all status, enables, vectors and controls, and leaves no
// priority level active.
// ----------------------------------------------------------------------------
module vectored_interrupt_controller
    import vic_pkg::*;
#(
    parameter int NUM_VECTORS = NUM_VECTORS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [11:0] offset,
    input  logic [31:0] write_data,
    input  logic [4:0]  line_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        access_error,
    output logic        irq_out,
    output logic        fiq_out
);

    logic        in_valid_reg,  in_valid_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  action_reg;
    logic [11:0] offset_reg;
    logic [31:0] wdata_reg;
    logic [4:0]  line_reg;
    logic [31:0] rdata_reg;
    logic        err_reg;
    logic        step;
    logic        in_take;
    logic [31:0] core_rdata;
    logic        core_err;

    // A held beat is processed when the output register is free or emptying.
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;
    assign in_take  = in_valid && in_ready;

    // Handshake state.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= action;
            offset_reg <= offset;
            wdata_reg  <= write_data;
            line_reg   <= line_index;
        end
    end

    vic_core #(
        .NUM_VECTORS (NUM_VECTORS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .action     (action_reg),
        .offset     (offset_reg),
        .write_data (wdata_reg),
        .line_index (line_reg),
        .rdata      (core_rdata),
        .err        (core_err),
        .irq        (irq_out),
        .fiq        (fiq_out)
    );

    // Output register.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rdata_reg <= core_rdata;
            err_reg   <= core_err;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rdata_reg;
    assign access_error = err_reg;

endmodule
